FILE: rtl/core/rebs_pkg.sv
package rebs_pkg;

    // Turn detector phases, also reported as turn_status.
    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_TURNING = 2'd1;
    localparam logic [1:0] PHASE_RIGHT   = 2'd2;
    localparam logic [1:0] PHASE_LEFT    = 2'd3;

    // Request kinds.
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_ADJUST = 1'b1;

    // Button sampler: number of stored samples before the vote slot.
    localparam int unsigned SAMPLE_COUNT = 3;
    localparam int unsigned SLOT_W       = $clog2(SAMPLE_COUNT + 1);
    localparam int unsigned SAMPLE_IDX_W = $clog2(SAMPLE_COUNT);

    // Configuration register map.
    localparam int unsigned PERIOD_W       = 8;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;
    localparam int unsigned ADDR_W         = 3;
    localparam int unsigned DATA_W         = 32;
    localparam logic [ADDR_W-1:2] REG_SAMPLE_PERIOD = 1'b0;

    localparam int unsigned VALUE_W = 16;

    typedef struct packed {
        logic               kind;
        logic               pin_a;
        logic               pin_b;
        logic               pin_button;
        logic [VALUE_W-1:0] value_in;
        logic [VALUE_W-1:0] low_bound;
        logic [VALUE_W-1:0] high_bound;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         turn_status;
        logic               button_pressed;
        logic [VALUE_W-1:0] value_out;
    } t_out_item;

    // Per-request control handed from the pipeline to the state units.
    typedef struct packed {
        logic step;
        logic kind;
    } t_step_ctrl;

endpackage

FILE: rtl/core/rotary_encoder_button_scanner.sv
// Rotary encoder and push-button scanner. Each request is a 1 ms tick with
// the A, B and button pin levels, or an adjust request that applies a
// latched click to a 16-bit value with wrap between the given bounds; every
// request yields exactly one result. A request is registered on entry,
// processed from that register against the turn and button state, and the
// result lands in an output register, so one request is taken per cycle
// while the output is not stalled. The button debounce period (sample_period,
// reset 10) sits at APB byte address 0; change it only while no request is in flight.
module rotary_encoder_button_scanner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  rebs_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output rebs_pkg::t_out_item             o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rebs_pkg::ADDR_W-1:0]     paddr,
    input  logic [rebs_pkg::DATA_W-1:0]     pwdata,
    output logic [rebs_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    logic                          r_s1_valid;
    rebs_pkg::t_in_item            r_s1_item;
    logic                          r_out_valid;
    rebs_pkg::t_out_item           r_out_data;
    rebs_pkg::t_out_item           n_out_data;
    rebs_pkg::t_step_ctrl          step_ctrl;
    logic                          advance;
    logic                          in_fire;
    logic [rebs_pkg::PERIOD_W-1:0] sample_period;
    logic [1:0]                    phase_next;
    logic                          pressed_next;
    logic [rebs_pkg::VALUE_W-1:0]  value_next;

    // Handshake: stage one moves on whenever the output register is free.
    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    assign step_ctrl.step = advance;
    assign step_ctrl.kind = r_s1_item.kind;

    rebs_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_sample_period (sample_period)
    );

    rebs_turn u_turn (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (step_ctrl),
        .i_item       (r_s1_item),
        .o_phase_next (phase_next),
        .o_value      (value_next)
    );

    rebs_button u_button (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (step_ctrl),
        .i_level         (r_s1_item.pin_button),
        .i_sample_period (sample_period),
        .o_pressed_next  (pressed_next)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_in_data;
        end
    end

    // Result register.
    always_comb begin
        n_out_data.turn_status    = phase_next;
        n_out_data.button_pressed = pressed_next;
        n_out_data.value_out      = value_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/core/rebs_apb_regs.sv
module rebs_apb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rebs_pkg::ADDR_W-1:0]      paddr,
    input  logic [rebs_pkg::DATA_W-1:0]      pwdata,
    output logic [rebs_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    output logic [rebs_pkg::PERIOD_W-1:0]    o_sample_period
);

    logic [rebs_pkg::PERIOD_W-1:0] r_sample_period;
    logic [rebs_pkg::PERIOD_W-1:0] n_sample_period;
    logic                          hit_period;

    assign pready     = 1'b1;
    assign hit_period = (paddr[rebs_pkg::ADDR_W-1:2] == rebs_pkg::REG_SAMPLE_PERIOD);

    // The register takes the low byte of the write data in the access phase.
    always_comb begin
        n_sample_period = r_sample_period;
        if (psel && penable && pwrite && hit_period) begin
            n_sample_period = pwdata[rebs_pkg::PERIOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= rebs_pkg::PERIOD_RESET;
        end else begin
            r_sample_period <= n_sample_period;
        end
    end

    // Read decode.
    always_comb begin
        prdata = '0;
        if (hit_period) begin
            prdata[rebs_pkg::PERIOD_W-1:0] = r_sample_period;
        end
    end

    assign o_sample_period = r_sample_period;

endmodule

FILE: rtl/core/rebs_turn.sv
module rebs_turn (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rebs_pkg::t_step_ctrl            i_ctrl,
    input  rebs_pkg::t_in_item              i_item,
    output logic [1:0]                      o_phase_next,
    output logic [rebs_pkg::VALUE_W-1:0]    o_value
);

    logic [1:0] r_phase;
    logic [1:0] n_phase;

    // Turn detection on ticks, click consumption on adjust requests.
    always_comb begin
        n_phase = r_phase;
        o_value = '0;
        if (i_ctrl.kind == rebs_pkg::KIND_TICK) begin
            unique case (r_phase)
                rebs_pkg::PHASE_IDLE: begin
                    if (!i_item.pin_a && !i_item.pin_b) begin
                        n_phase = rebs_pkg::PHASE_TURNING;
                    end
                end
                rebs_pkg::PHASE_TURNING: begin
                    if (!i_item.pin_a && i_item.pin_b) begin
                        n_phase = rebs_pkg::PHASE_RIGHT;
                    end else if (i_item.pin_a && !i_item.pin_b) begin
                        n_phase = rebs_pkg::PHASE_LEFT;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end else begin
            o_value = i_item.value_in;
            if (r_phase == rebs_pkg::PHASE_RIGHT) begin
                o_value = (i_item.value_in < i_item.high_bound) ?
                          i_item.value_in + 16'd1 : i_item.low_bound;
                n_phase = rebs_pkg::PHASE_IDLE;
            end else if (r_phase == rebs_pkg::PHASE_LEFT) begin
                o_value = (i_item.value_in > i_item.low_bound) ?
                          i_item.value_in - 16'd1 : i_item.high_bound;
                n_phase = rebs_pkg::PHASE_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rebs_pkg::PHASE_IDLE;
        end else if (i_ctrl.step) begin
            r_phase <= n_phase;
        end
    end

    assign o_phase_next = n_phase;

endmodule

FILE: rtl/core/rebs_button.sv
module rebs_button (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rebs_pkg::t_step_ctrl            i_ctrl,
    input  logic                            i_level,
    input  logic [rebs_pkg::PERIOD_W-1:0]   i_sample_period,
    output logic                            o_pressed_next
);

    localparam int unsigned SampleCount = rebs_pkg::SAMPLE_COUNT;
    localparam int unsigned SlotW       = rebs_pkg::SLOT_W;
    localparam int unsigned IdxW        = rebs_pkg::SAMPLE_IDX_W;

    logic [rebs_pkg::PERIOD_W-1:0] r_tick_count;
    logic [rebs_pkg::PERIOD_W-1:0] n_tick_count;
    logic [SlotW-1:0]              r_slot;
    logic [SlotW-1:0]              n_slot;
    logic [SampleCount-1:0]        r_samples;
    logic [SampleCount-1:0]        n_samples;
    logic                          r_pressed;
    logic                          n_pressed;
    logic [rebs_pkg::PERIOD_W-1:0] count_inc;
    logic [SlotW-1:0]              lows;

    assign count_inc = r_tick_count + 8'd1;

    // Count low samples for the two-of-three vote.
    always_comb begin
        lows = '0;
        for (int k = 0; k < SampleCount; k++) begin
            lows = lows + SlotW'(!r_samples[k]);
        end
    end

    // One sample slot every sample_period ticks; the slot after the last
    // stored sample takes the vote instead of a sample.
    always_comb begin
        n_tick_count = r_tick_count;
        n_slot       = r_slot;
        n_samples    = r_samples;
        n_pressed    = r_pressed;
        if (i_ctrl.kind == rebs_pkg::KIND_TICK) begin
            n_tick_count = count_inc;
            if (count_inc >= i_sample_period) begin
                n_tick_count = '0;
                if (r_slot < SlotW'(SampleCount)) begin
                    n_samples[r_slot[IdxW-1:0]] = i_level;
                    n_slot = r_slot + SlotW'(1);
                end else begin
                    n_slot    = '0;
                    n_pressed = (lows >= SlotW'(2));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_slot       <= '0;
            r_samples    <= '0;
            r_pressed    <= 1'b0;
        end else if (i_ctrl.step) begin
            r_tick_count <= n_tick_count;
            r_slot       <= n_slot;
            r_samples    <= n_samples;
            r_pressed    <= n_pressed;
        end
    end

    assign o_pressed_next = n_pressed;

endmodule

FILE: rtl/core/rebs_checker.sv
module rebs_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  rebs_pkg::t_out_item             o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rebs_pkg::ADDR_W-1:0]     paddr,
    input  logic [rebs_pkg::DATA_W-1:0]     pwdata,
    input  logic [rebs_pkg::DATA_W-1:0]     prdata
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // With no result waiting the block must take a request.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused with empty output");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A written period reads back on the next cycle.
    a_period_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[rebs_pkg::ADDR_W-1:2] == rebs_pkg::REG_SAMPLE_PERIOD))
        |=> ((paddr[rebs_pkg::ADDR_W-1:2] != rebs_pkg::REG_SAMPLE_PERIOD) ||
             (prdata[rebs_pkg::PERIOD_W-1:0] == $past(pwdata[rebs_pkg::PERIOD_W-1:0]))))
        else $error("sample period readback mismatch");

endmodule

bind rotary_encoder_button_scanner rebs_checker u_rebs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_PER_PHASE = 182;
    localparam int unsigned IDLE_PCT         = 15;
    localparam int unsigned HOLD_AT_RESULT   = 300;
    localparam int unsigned HOLD_CYCLES      = 120;
    localparam int unsigned CALM_FIRST       = 500;
    localparam int unsigned CALM_LAST        = 700;
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned QUIET_LIMIT      = 4000;

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_ADJUST,
        ROW_PERIOD
    } t_row_op;

    // One line of the directed stimulus. For a period row, v carries the new period.
    typedef struct {
        t_row_op     op;
        bit          a;
        bit          b;
        bit          btn;
        logic [15:0] v;
        logic [15:0] lo;
        logic [15:0] hi;
        bit          typed;
        logic [1:0]  st;
        bit          pr;
        logic [15:0] vo;
    } t_drow;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    rebs_pkg::t_in_item            i_in_data;
    logic                          o_out_valid;
    logic                          i_out_ready;
    rebs_pkg::t_out_item           o_out_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [rebs_pkg::ADDR_W-1:0]   paddr;
    logic [rebs_pkg::DATA_W-1:0]   pwdata;
    logic [rebs_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    rotary_encoder_button_scanner dut (.*);

    // Scanner state as the predictor tracks it.
    logic [rebs_pkg::PERIOD_W-1:0] sim_period;
    logic [1:0]                    sim_phase;
    logic [7:0]                    sim_ticks;
    logic [rebs_pkg::SLOT_W-1:0]   sim_slot;
    logic                          sim_samples [rebs_pkg::SAMPLE_COUNT];
    logic                          sim_pressed;
    logic                          btn_level;

    rebs_pkg::t_out_item scan_results_due [$];
    rebs_pkg::t_out_item oldest_due;
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned requests_sent;
    int unsigned adjusts_sent;
    int unsigned clicks_applied;
    int unsigned votes_taken;
    int unsigned period_writes;
    int unsigned quiet_cycles;

    t_drow directed_rows [27] = '{
        '{ROW_TICK,   1, 1, 1, 16'h0000, 16'h0000, 16'h0000, 1, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_ADJUST, 0, 0, 0, 16'd1234, 16'h0000, 16'hFFFF, 1, rebs_pkg::PHASE_IDLE, 0, 16'd1234},
        '{ROW_TICK,   0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 1, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_PERIOD, 0, 0, 0, 16'd0,    16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_ADJUST, 0, 0, 0, 16'd77,   16'd0,    16'd100,  0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   0, 1, 1, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   1, 1, 1, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_ADJUST, 0, 0, 0, 16'hFFFF, 16'h0000, 16'hFFFF, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   0, 0, 1, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   1, 0, 1, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_ADJUST, 0, 0, 0, 16'h0000, 16'h0000, 16'hFFFF, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   1, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_ADJUST, 0, 0, 0, 16'd100,  16'd500,  16'd50,   0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_ADJUST, 0, 0, 0, 16'd100,  16'd500,  16'd50,   0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_PERIOD, 0, 0, 0, 16'd255,  16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   0, 0, 1, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   0, 1, 1, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_ADJUST, 0, 0, 0, 16'h7FFF, 16'h0000, 16'hFFFF, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_PERIOD, 0, 0, 0, 16'd1,    16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_TICK,   1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0},
        '{ROW_ADJUST, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'h0000, 0, rebs_pkg::PHASE_IDLE, 0, 16'd0}
    };

    // Works out the result of one request and advances the tracked state.
    function automatic rebs_pkg::t_out_item predict_scan(rebs_pkg::t_in_item req);
        rebs_pkg::t_out_item          res;
        logic [rebs_pkg::VALUE_W-1:0] v;
        int unsigned                  lows;
        v = '0;
        if (req.kind == rebs_pkg::KIND_TICK) begin
            // Turn detector: idle arms on both low, turning latches a direction.
            if (sim_phase == rebs_pkg::PHASE_IDLE) begin
                if (!req.pin_a && !req.pin_b) sim_phase = rebs_pkg::PHASE_TURNING;
            end else if (sim_phase == rebs_pkg::PHASE_TURNING) begin
                if (!req.pin_a && req.pin_b) sim_phase = rebs_pkg::PHASE_RIGHT;
                else if (req.pin_a && !req.pin_b) sim_phase = rebs_pkg::PHASE_LEFT;
            end
            // Button sampler: three stored slots, then a majority vote slot.
            sim_ticks = sim_ticks + 8'd1;
            if (sim_ticks >= sim_period) begin
                sim_ticks = '0;
                if (sim_slot < rebs_pkg::SAMPLE_COUNT) begin
                    sim_samples[sim_slot] = req.pin_button;
                    sim_slot = sim_slot + 1'b1;
                end else begin
                    sim_slot = '0;
                    lows = 0;
                    for (int k = 0; k < rebs_pkg::SAMPLE_COUNT; k++) begin
                        if (!sim_samples[k]) lows++;
                    end
                    sim_pressed = (lows >= 2);
                    votes_taken++;
                end
            end
        end else begin
            // A latched click steps the value with wrap and clears the latch.
            v = req.value_in;
            adjusts_sent++;
            if (sim_phase == rebs_pkg::PHASE_RIGHT) begin
                v = (v < req.high_bound) ? v + 16'd1 : req.low_bound;
                sim_phase = rebs_pkg::PHASE_IDLE;
                clicks_applied++;
            end else if (sim_phase == rebs_pkg::PHASE_LEFT) begin
                v = (v > req.low_bound) ? v - 16'd1 : req.high_bound;
                sim_phase = rebs_pkg::PHASE_IDLE;
                clicks_applied++;
            end
        end
        res.turn_status    = sim_phase;
        res.button_pressed = sim_pressed;
        res.value_out      = v;
        return res;
    endfunction

    // A tick with the given encoder levels; the button drifts slowly with some chatter.
    function automatic rebs_pkg::t_in_item random_tick(bit a, bit b);
        rebs_pkg::t_in_item req;
        if ($urandom_range(0, 9) == 0) btn_level = ~btn_level;
        req.kind       = rebs_pkg::KIND_TICK;
        req.pin_a      = a;
        req.pin_b      = b;
        req.pin_button = ($urandom_range(0, 9) == 0) ? ~btn_level : btn_level;
        req.value_in   = rebs_pkg::VALUE_W'($urandom);
        req.low_bound  = rebs_pkg::VALUE_W'($urandom);
        req.high_bound = rebs_pkg::VALUE_W'($urandom);
        return req;
    endfunction

    // An adjust request, mostly with ordered bounds and the value near a bound.
    function automatic rebs_pkg::t_in_item random_adjust();
        rebs_pkg::t_in_item           req;
        logic [rebs_pkg::VALUE_W-1:0] lo;
        logic [rebs_pkg::VALUE_W-1:0] hi;
        lo = rebs_pkg::VALUE_W'($urandom);
        hi = rebs_pkg::VALUE_W'($urandom);
        if (lo > hi && $urandom_range(0, 3) != 0) begin
            req.low_bound = hi;
            hi = lo;
            lo = req.low_bound;
        end
        req.kind       = rebs_pkg::KIND_ADJUST;
        req.pin_a      = 1'($urandom);
        req.pin_b      = 1'($urandom);
        req.pin_button = 1'($urandom);
        req.low_bound  = lo;
        req.high_bound = hi;
        case ($urandom_range(0, 3))
            0: req.value_in = lo;
            1: req.value_in = hi;
            2: req.value_in = rebs_pkg::VALUE_W'($urandom);
            default: req.value_in = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        return req;
    endfunction

    // Presents one request, waits for it to be taken and records its result.
    task automatic offer_request(rebs_pkg::t_in_item req, bit typed,
                                 rebs_pkg::t_out_item want);
        rebs_pkg::t_out_item due;
        bit                  calm;
        calm = (requests_sent >= CALM_FIRST && requests_sent < CALM_LAST);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        due = predict_scan(req);
        scan_results_due.push_back(typed ? want : due);
        requests_sent++;
    endtask

    // One APB transfer; psel is left high so transfers can run back to back.
    task automatic apb_transfer(bit wr, logic [rebs_pkg::ADDR_W-1:0] addr,
                                logic [rebs_pkg::DATA_W-1:0] wdata,
                                output logic [rebs_pkg::DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic read_period_reg(logic [rebs_pkg::PERIOD_W-1:0] want);
        logic [rebs_pkg::DATA_W-1:0] got;
        apb_transfer(1'b0, {rebs_pkg::REG_SAMPLE_PERIOD, 2'b00}, '0, got);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[rebs_pkg::PERIOD_W-1:0] !== want) begin
            $display("%0t: sample_period read: expected %0d, got %0d", $time, want,
                     got[rebs_pkg::PERIOD_W-1:0]);
            mismatches++;
        end
    endtask

    // Changes the sample period once every outstanding result has come back.
    task automatic set_sample_period(logic [rebs_pkg::PERIOD_W-1:0] p);
        logic [rebs_pkg::DATA_W-1:0] unused;
        i_in_valid <= 1'b0;
        while (scan_results_due.size() != 0) @(posedge i_clk);
        apb_transfer(1'b1, {rebs_pkg::REG_SAMPLE_PERIOD, 2'b00},
                     rebs_pkg::DATA_W'(p), unused);
        read_period_reg(p);
        sim_period = p;
        period_writes++;
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result side: random stalls, one long hold-off and one stretch without stalls.
    initial begin : result_side
        int unsigned taken;
        bit          held;
        bit          calm;
        taken = 0;
        held  = 0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && taken == HOLD_AT_RESULT) begin
                held = 1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            calm = (taken >= CALM_FIRST + 20 && taken < CALM_LAST + 20);
            i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) taken++;
        end
    end

    // Compare every result with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (scan_results_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %0d/%0d/0x%04h",
                         $time, o_out_data.turn_status, o_out_data.button_pressed,
                         o_out_data.value_out);
                mismatches++;
            end else begin
                oldest_due = scan_results_due.pop_front();
                if (oldest_due.turn_status !== o_out_data.turn_status ||
                    oldest_due.button_pressed !== o_out_data.button_pressed ||
                    oldest_due.value_out !== o_out_data.value_out) begin
                    $display("%0t: result mismatch (status/pressed/value): %s %0d/%0d/0x%04h, %s",
                             $time, "expected", oldest_due.turn_status,
                             oldest_due.button_pressed, oldest_due.value_out, "got");
                    $display("%0t:     actual %0d/%0d/0x%04h", $time,
                             o_out_data.turn_status, o_out_data.button_pressed,
                             o_out_data.value_out);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: watchdog: nothing moved for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: reset, directed table, then randomized phases at several periods.
    initial begin : stimulus
        rebs_pkg::t_in_item            req;
        rebs_pkg::t_out_item           want;
        logic [rebs_pkg::PERIOD_W-1:0] phase_periods [5];
        int unsigned                   phase_end;
        bit                            dir;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        sim_period  = rebs_pkg::PERIOD_RESET;
        sim_phase   = rebs_pkg::PHASE_IDLE;
        sim_ticks   = '0;
        sim_slot    = '0;
        sim_pressed = 1'b0;
        btn_level   = 1'b1;
        for (int k = 0; k < rebs_pkg::SAMPLE_COUNT; k++) sim_samples[k] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The period register comes out of reset at its default.
        read_period_reg(8'd10);

        // Directed table.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_PERIOD) begin
                set_sample_period(directed_rows[i].v[rebs_pkg::PERIOD_W-1:0]);
            end else begin
                req            = '0;
                req.kind       = (directed_rows[i].op == ROW_TICK) ?
                                 rebs_pkg::KIND_TICK : rebs_pkg::KIND_ADJUST;
                req.pin_a      = directed_rows[i].a;
                req.pin_b      = directed_rows[i].b;
                req.pin_button = directed_rows[i].btn;
                req.value_in   = directed_rows[i].v;
                req.low_bound  = directed_rows[i].lo;
                req.high_bound = directed_rows[i].hi;
                want.turn_status    = directed_rows[i].st;
                want.button_pressed = directed_rows[i].pr;
                want.value_out      = directed_rows[i].vo;
                offer_request(req, directed_rows[i].typed, want);
            end
        end

        // Random phases; most traffic is complete turn-and-adjust sequences.
        phase_periods = '{8'd1, 8'd255, 8'd0,
                          rebs_pkg::PERIOD_W'($urandom_range(2, 12)), 8'd3};
        foreach (phase_periods[ph]) begin
            set_sample_period(phase_periods[ph]);
            phase_end = requests_sent + RANDOM_PER_PHASE;
            while (requests_sent < phase_end) begin
                if ($urandom_range(0, 99) < 65) begin
                    repeat ($urandom_range(0, 3))
                        offer_request(random_tick(1'($urandom), 1'($urandom)), 0, '0);
                    offer_request(random_tick(1'b0, 1'b0), 0, '0);
                    repeat ($urandom_range(0, 2)) begin
                        dir = 1'($urandom);
                        offer_request(random_tick(dir, dir), 0, '0);
                    end
                    dir = 1'($urandom);
                    offer_request(random_tick(dir, ~dir), 0, '0);
                    repeat ($urandom_range(0, 2))
                        offer_request(random_tick(1'($urandom), 1'($urandom)), 0, '0);
                    offer_request(random_adjust(), 0, '0);
                end else if ($urandom_range(0, 1) == 0) begin
                    offer_request(random_adjust(), 0, '0);
                end else begin
                    offer_request(random_tick(1'($urandom), 1'($urandom)), 0, '0);
                end
            end
        end

        // Let the pipeline empty out, then report.
        i_in_valid <= 1'b0;
        while (scan_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run: %0d requests checked over %0d period settings, %0d adjusts.",
                 results_seen, period_writes, adjusts_sent);
        $display("%0d clicks applied, %0d majority votes, one output stall of %0d cycles.",
                 clicks_applied, votes_taken, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
